/* src/imu_quaternion_report_to_euler_assert.svh */
// assertion macros used by the orientation report controller
`ifndef IMU_QUATERNION_REPORT_TO_EULER_ASSERT_SVH
`define IMU_QUATERNION_REPORT_TO_EULER_ASSERT_SVH

// plain property on i_clk, off while reset is low
`define IQE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition checked in the cycle after the antecedent
`define IQE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/iqe_pkg.sv */
// shared constants, types and tables of the orientation report converter
package iqe_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 18;
    localparam int ACC_FRAC        = 24;
    localparam int ANG_SH          = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int ACC_SH          = 30 - ANGLE_FRAC_BITS;

    localparam int Q16_W  = 20;
    localparam int PACC_W = 40;
    localparam int CW     = 42;
    localparam int ZW     = 35;
    localparam int AW     = 34;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;
    localparam int SQ_W   = 62;
    localparam int ROOT_W = 31;
    localparam int YAW_W  = ANGLE_FRAC_BITS + 9;
    localparam int K_W    = $clog2(CORDIC_STEPS);

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'd180 << ACC_FRAC);
    localparam logic signed [AW-1:0] FULL_TURN = AW'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] ANG_HALF  = ZW'(64'd1 << (ANG_SH - 1));
    localparam logic signed [PROD_W-1:0] ACC_HALF = PROD_W'(64'd1 << (ACC_SH - 1));
    localparam logic signed [PACC_W-1:0] ONE_Q31  = PACC_W'(64'd1 << 31);
    localparam logic signed [MUL_W-1:0] HALF_SQRT2_Q16 = 32'sd46341;
    localparam logic signed [MUL_W-1:0] RAD_TO_DEG_Q16 = 32'sd3754936;
    localparam logic [K_W-1:0] K_LAST = K_W'(CORDIC_STEPS - 1);

    localparam logic [14:0] LEN_REAL_MIN = 15'd18;
    localparam logic [14:0] LEN_ACC_MIN  = 15'd20;

    localparam logic       REQ_SET     = 1'b1;
    localparam logic       CFG_ROT_ID  = 1'b0;
    localparam logic       CFG_GAME_ID = 1'b1;
    localparam logic [1:0] TGT_ROT     = 2'd0;
    localparam logic [1:0] TGT_GAME    = 2'd1;
    localparam logic [1:0] TGT_AZ      = 2'd2;
    localparam logic [1:0] PH_YAW      = 2'd0;
    localparam logic [1:0] PH_PITCH    = 2'd1;
    localparam logic [1:0] PH_ROLL     = 2'd2;

    // multiplier schedule
    localparam logic [3:0] MS_Q0  = 4'd0;
    localparam logic [3:0] MS_Q1  = 4'd1;
    localparam logic [3:0] MS_Q2  = 4'd2;
    localparam logic [3:0] MS_Q3  = 4'd3;
    localparam logic [3:0] MS_IJ  = 4'd4;
    localparam logic [3:0] MS_RK  = 4'd5;
    localparam logic [3:0] MS_RR0 = 4'd6;
    localparam logic [3:0] MS_II  = 4'd7;
    localparam logic [3:0] MS_RI  = 4'd8;
    localparam logic [3:0] MS_JK  = 4'd9;
    localparam logic [3:0] MS_RR1 = 4'd10;
    localparam logic [3:0] MS_KK  = 4'd11;
    localparam logic [3:0] MS_IK  = 4'd12;
    localparam logic [3:0] MS_RJ  = 4'd13;
    localparam logic [3:0] MS_ACC = 4'd14;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_VCLAMP, S_VSQ, S_CLOAD, S_CITER, S_CEND, S_FIN
    } t_state;

    typedef struct packed {
        logic           load;
        logic           set;
        logic           mul_en;
        logic [3:0]     mul_step;
        logic           vclamp;
        logic           vsq;
        logic           cload;
        logic           citer;
        logic [K_W-1:0] k;
        logic           cend;
        logic [1:0]     phase;
        logic           out_load;
    } t_cmd;

    typedef struct packed {
        logic req_set;
        logic id_hit;
        logic sqrt_done;
    } t_sts;

    // arctan of 2^-k in degrees * 2^24
    function automatic logic [31:0] atan_q24(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489089;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            5'd20: v = 32'd917;
            5'd21: v = 32'd458;
            5'd22: v = 32'd229;
            5'd23: v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/iqe_sqrt.sv */
// iterative integer square root, two radicand bits per cycle
module iqe_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [iqe_pkg::SQ_W-1:0]  i_value,
    output logic [iqe_pkg::ROOT_W-1:0] o_root,
    output logic                      o_done
);
    import iqe_pkg::*;

    logic [SQ_W-1:0] r_rem, r_res, r_bit;
    logic            r_busy, r_done;
    logic [SQ_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_value;
            r_res <= '0;
            r_bit <= SQ_W'(64'd1 << 60);
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[ROOT_W-1:0];
    assign o_done = r_done;
endmodule

/* src/iqe_dp.sv */
// datapath: turn, shared multiplier, cordic, yaw correction and result register
module iqe_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iqe_pkg::t_cmd       i_cmd,
    output iqe_pkg::t_sts       o_sts,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_req_type,
    input  logic [15:0]         i_header_length,
    input  logic [7:0]          i_report_id,
    input  logic [1:0]          i_status_bits,
    input  logic signed [15:0]  i_quat_i,
    input  logic signed [15:0]  i_quat_j,
    input  logic signed [15:0]  i_quat_k,
    input  logic signed [15:0]  i_quat_real,
    input  logic signed [15:0]  i_radian_accuracy,
    input  logic [1:0]          i_target_vector,
    input  logic signed [25:0]  i_angle_value,
    output logic                o_vector_kind,
    output logic [24:0]         o_yaw_deg,
    output logic signed [24:0]  o_pitch_deg,
    output logic signed [23:0]  o_roll_deg,
    output logic signed [23:0]  o_accuracy_deg,
    output logic [1:0]          o_accuracy_status,
    output logic signed [15:0]  o_rot_real,
    output logic signed [15:0]  o_rot_i,
    output logic signed [15:0]  o_rot_j,
    output logic signed [15:0]  o_rot_k
);
    import iqe_pkg::*;

    logic [7:0] r_rot_id, r_game_id;
    logic signed [31:0] r_rot_off, r_game_off;
    logic [YAW_W-1:0] r_last_rot, r_last_game;

    logic r_kind;
    logic [1:0] r_status;
    logic signed [15:0] r_qi, r_qj, r_qk, r_qr, r_acc_in;

    logic signed [Q16_W-1:0] r_q16 [4];
    logic signed [15:0] r_q14 [4];
    logic signed [PACC_W-1:0] r_yy, r_yx, r_py, r_px, r_vd;
    logic signed [23:0] r_accd;
    logic signed [MUL_W-1:0] r_vc;

    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic signed [AW-1:0] r_raw, r_pitch, r_roll;

    logic signed [16:0] s_q [4];
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod, t16, t14, tacc, sqv;
    logic signed [PACC_W-1:0] p40;
    logic [ROOT_W-1:0] root;
    logic sqrt_done;
    logic [14:0] len;

    logic signed [CW-1:0] ld_x, ld_y, xs, ys;
    logic signed [ZW-1:0] at, zc, za;
    logic signed [AW-1:0] ang, raw_n, yaw;
    logic signed [31:0] off;

    assign len = i_header_length[14:0];
    assign o_sts.req_set   = (i_req_type == REQ_SET);
    assign o_sts.id_hit    = (i_report_id == r_rot_id) || (i_report_id == r_game_id);
    assign o_sts.sqrt_done = sqrt_done;

    assign s_q[0] = 17'(r_qr) - 17'(r_qj);
    assign s_q[1] = 17'(r_qi) - 17'(r_qk);
    assign s_q[2] = 17'(r_qr) + 17'(r_qj);
    assign s_q[3] = 17'(r_qi) + 17'(r_qk);

    // one shared multiplier, operands picked by the schedule step or by the sine argument square
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.vsq) begin
            mul_a = r_vc;
            mul_b = r_vc;
        end else if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_step)
                MS_Q0:  begin mul_a = 32'(s_q[0]); mul_b = HALF_SQRT2_Q16; end
                MS_Q1:  begin mul_a = 32'(s_q[1]); mul_b = HALF_SQRT2_Q16; end
                MS_Q2:  begin mul_a = 32'(s_q[2]); mul_b = HALF_SQRT2_Q16; end
                MS_Q3:  begin mul_a = 32'(s_q[3]); mul_b = HALF_SQRT2_Q16; end
                MS_IJ:  begin mul_a = 32'(r_q16[1]); mul_b = 32'(r_q16[2]); end
                MS_RK:  begin mul_a = 32'(r_q16[0]); mul_b = 32'(r_q16[3]); end
                MS_RR0: begin mul_a = 32'(r_q16[0]); mul_b = 32'(r_q16[0]); end
                MS_II:  begin mul_a = 32'(r_q16[1]); mul_b = 32'(r_q16[1]); end
                MS_RI:  begin mul_a = 32'(r_q16[0]); mul_b = 32'(r_q16[1]); end
                MS_JK:  begin mul_a = 32'(r_q16[2]); mul_b = 32'(r_q16[3]); end
                MS_RR1: begin mul_a = 32'(r_q16[0]); mul_b = 32'(r_q16[0]); end
                MS_KK:  begin mul_a = 32'(r_q16[3]); mul_b = 32'(r_q16[3]); end
                MS_IK:  begin mul_a = 32'(r_q16[1]); mul_b = 32'(r_q16[3]); end
                MS_RJ:  begin mul_a = 32'(r_q16[0]); mul_b = 32'(r_q16[2]); end
                MS_ACC: begin mul_a = 32'(r_acc_in); mul_b = RAD_TO_DEG_Q16; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign p40  = prod[PACC_W-1:0];
    assign t16  = (prod + 64'sd8192) >>> 14;
    assign t14  = (prod + 64'sd32768) >>> 16;
    assign tacc = (prod + ACC_HALF) >>> ACC_SH;
    assign sqv  = (64'sd1 <<< 60) - prod;

    iqe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.vsq),
        .i_value (sqv[SQ_W-1:0]),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    // config and correction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_id    <= 8'd5;
            r_game_id   <= 8'd8;
            r_rot_off   <= '0;
            r_game_off  <= '0;
            r_last_rot  <= '0;
            r_last_game <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROT_ID) r_rot_id <= i_cfg_data;
                else                           r_game_id <= i_cfg_data;
            end
            if (i_cmd.set) begin
                unique case (i_target_vector)
                    TGT_ROT:  r_rot_off <= 32'(i_angle_value);
                    TGT_GAME: r_game_off <= 32'(i_angle_value);
                    TGT_AZ: begin
                        r_rot_off  <= 32'(i_angle_value) - 32'(r_last_rot);
                        r_game_off <= 32'(i_angle_value) - 32'(r_last_game);
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                if (r_kind) r_last_game <= r_raw[YAW_W-1:0];
                else        r_last_rot  <= r_raw[YAW_W-1:0];
            end
        end
    end

    // input item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= (i_report_id != r_rot_id);
            r_status <= i_status_bits;
            r_qi     <= i_quat_i;
            r_qj     <= i_quat_j;
            r_qk     <= i_quat_k;
            r_qr     <= (len > LEN_REAL_MIN) ? i_quat_real : 16'sd0;
            r_acc_in <= (len > LEN_ACC_MIN) ? i_radian_accuracy : 16'sd0;
        end
    end

    // multiplier results
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_step)
                MS_Q0, MS_Q1, MS_Q2, MS_Q3: begin
                    r_q16[i_cmd.mul_step[1:0]] <= t16[Q16_W-1:0];
                    if (t14 > 64'sd32767)       r_q14[i_cmd.mul_step[1:0]] <= 16'sh7fff;
                    else if (t14 < -64'sd32768) r_q14[i_cmd.mul_step[1:0]] <= -16'sh8000;
                    else                        r_q14[i_cmd.mul_step[1:0]] <= t14[15:0];
                end
                MS_IJ:  r_yy <= p40;
                MS_RK:  r_yy <= r_yy + p40;
                MS_RR0: r_yx <= p40;
                MS_II:  r_yx <= r_yx + p40 - ONE_Q31;
                MS_RI:  r_py <= p40;
                MS_JK:  r_py <= r_py + p40;
                MS_RR1: r_px <= p40;
                MS_KK:  r_px <= r_px + p40 - ONE_Q31;
                MS_IK:  r_vd <= p40;
                MS_RJ:  r_vd <= r_vd - p40;
                MS_ACC: r_accd <= tacc[23:0];
                default: ;
            endcase
        end
        if (i_cmd.vclamp) begin
            // sine argument clamped to plus or minus one in Q30
            if ((r_vd >>> 1) > (PACC_W'(1) <<< 30))        r_vc <= 32'sd1 <<< 30;
            else if ((r_vd >>> 1) < -(PACC_W'(1) <<< 30))  r_vc <= -(32'sd1 <<< 30);
            else                                         r_vc <= 32'(r_vd >>> 1);
        end
    end

    // cordic vectoring
    always_comb begin
        unique case (i_cmd.phase)
            PH_YAW:   begin ld_y = CW'(r_yy); ld_x = CW'(r_yx); end
            PH_PITCH: begin ld_y = CW'(r_py); ld_x = CW'(r_px); end
            default:  begin ld_y = CW'(r_vc); ld_x = CW'({1'b0, root}); end
        endcase
        xs = r_cx >>> i_cmd.k;
        ys = r_cy >>> i_cmd.k;
        at = ZW'(atan_q24(5'(i_cmd.k)));
        if (r_cz > HALF_TURN)       zc = HALF_TURN;
        else if (r_cz < -HALF_TURN) zc = -HALF_TURN;
        else                        zc = r_cz;
        za  = (zc + ANG_HALF) >>> ANG_SH;
        ang = AW'(za);
        raw_n = -ang;
        if (raw_n < 0) raw_n = raw_n + FULL_TURN;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cload) begin
            if (ld_x < 0) begin
                r_cx <= -ld_x;
                r_cy <= -ld_y;
                r_cz <= (ld_y >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                r_cx <= ld_x;
                r_cy <= ld_y;
                r_cz <= '0;
            end
        end else if (i_cmd.citer) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + at;
            end else begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - at;
            end
        end
        if (i_cmd.cend) begin
            unique case (i_cmd.phase)
                PH_YAW:   r_raw   <= raw_n;
                PH_PITCH: r_pitch <= ang;
                default:  r_roll  <= -ang;
            endcase
        end
    end

    // yaw correction and wrap
    always_comb begin
        off = r_kind ? r_game_off : r_rot_off;
        yaw = r_raw + AW'(off);
        if (yaw > FULL_TURN) yaw = yaw - FULL_TURN;
        if (yaw < 0)         yaw = yaw + FULL_TURN;
        if (yaw < 0)              yaw = '0;
        else if (yaw > FULL_TURN) yaw = FULL_TURN;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_vector_kind     <= r_kind;
            o_yaw_deg         <= yaw[24:0];
            o_pitch_deg       <= r_pitch[24:0];
            o_roll_deg        <= r_roll[23:0];
            o_accuracy_deg    <= r_accd;
            o_accuracy_status <= r_status;
            o_rot_real        <= r_q14[0];
            o_rot_i           <= r_q14[1];
            o_rot_j           <= r_q14[2];
            o_rot_k           <= r_q14[3];
        end
    end
endmodule

/* src/iqe_ctrl.sv */
// controller: sequences multiplier, square root and cordic, owns the handshakes
`include "imu_quaternion_report_to_euler_assert.svh"
module iqe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  iqe_pkg::t_sts i_sts,
    output iqe_pkg::t_cmd o_cmd
);
    import iqe_pkg::*;

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [K_W-1:0] r_k, n_k;
    logic [1:0] r_phase, n_phase;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_k         <= '0;
            r_phase     <= PH_YAW;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_k         <= n_k;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_k        = r_k;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_cmd.mul_step = r_step;
        o_cmd.k        = r_k;
        o_cmd.phase    = r_phase;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.req_set) begin
                        o_cmd.set = 1'b1;
                    end else if (i_sts.id_hit) begin
                        n_state = S_MUL;
                        n_step  = MS_Q0;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_step == MS_ACC) n_state = S_VCLAMP;
                else                  n_step  = r_step + 4'd1;
            end
            S_VCLAMP: begin
                o_cmd.vclamp = 1'b1;
                n_state = S_VSQ;
            end
            S_VSQ: begin
                o_cmd.vsq = 1'b1;
                n_phase = PH_YAW;
                n_state = S_CLOAD;
            end
            S_CLOAD: begin
                // roll needs the square root result
                if (r_phase != PH_ROLL || i_sts.sqrt_done) begin
                    o_cmd.cload = 1'b1;
                    n_k     = '0;
                    n_state = S_CITER;
                end
            end
            S_CITER: begin
                o_cmd.citer = 1'b1;
                if (r_k == K_LAST) n_state = S_CEND;
                else               n_k     = r_k + K_W'(1);
            end
            S_CEND: begin
                o_cmd.cend = 1'b1;
                if (r_phase == PH_ROLL) begin
                    n_state = S_FIN;
                end else begin
                    n_phase = r_phase + 2'd1;
                    n_state = S_CLOAD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.out_load)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    assign o_out_valid = r_out_valid;

    `IQE_ASSERT_NEXT(a_known_report_starts, i_in_valid && o_in_ready && !i_sts.req_set && i_sts.id_hit, r_state == S_MUL, "known report did not start the multiplier schedule")
    `IQE_ASSERT(a_roll_after_sqrt, !(r_state == S_CITER && r_phase == PH_ROLL) || i_sts.sqrt_done, "roll cordic ran before the square root finished")
    `IQE_ASSERT(a_step_range, r_state != S_MUL || r_step <= MS_ACC, "multiplier step out of schedule")
    `IQE_ASSERT(a_out_slot_free, !o_cmd.out_load || !r_out_valid || i_out_ready, "result register overwritten before it was taken")
endmodule

/* src/imu_quaternion_report_to_euler.sv */
// top level of the orientation report to euler angle converter
//
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_ready     request type, report fields, correction
//  out      output     o_out_valid / i_out_ready   kind, yaw, pitch, roll, accuracy, quaternion
//  cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// a known report passes 15 steps on the shared multiplier, the clamp and square steps for the
// sine argument, three cordic runs on one unit (yaw, pitch, roll) and a finish step
// set requests and unknown report ids are taken in the idle state and give no item
// the square root runs beside the yaw and pitch cordic runs
// the result register lets a new item in while the last result waits; a full register
// stalls the finish step. reset is synchronous and needs no clearing pass
module imu_quaternion_report_to_euler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [15:0]        i_header_length,
    input  logic [7:0]         i_report_id,
    input  logic [1:0]         i_status_bits,
    input  logic signed [15:0] i_quat_i,
    input  logic signed [15:0] i_quat_j,
    input  logic signed [15:0] i_quat_k,
    input  logic signed [15:0] i_quat_real,
    input  logic signed [15:0] i_radian_accuracy,
    input  logic [1:0]         i_target_vector,
    input  logic signed [25:0] i_angle_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_vector_kind,
    output logic [24:0]        o_yaw_deg,
    output logic signed [24:0] o_pitch_deg,
    output logic signed [23:0] o_roll_deg,
    output logic signed [23:0] o_accuracy_deg,
    output logic [1:0]         o_accuracy_status,
    output logic signed [15:0] o_rot_real,
    output logic signed [15:0] o_rot_i,
    output logic signed [15:0] o_rot_j,
    output logic signed [15:0] o_rot_k,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import iqe_pkg::*;

    t_cmd cmd;
    t_sts sts;

    iqe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iqe_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_header_length   (i_header_length),
        .i_report_id       (i_report_id),
        .i_status_bits     (i_status_bits),
        .i_quat_i          (i_quat_i),
        .i_quat_j          (i_quat_j),
        .i_quat_k          (i_quat_k),
        .i_quat_real       (i_quat_real),
        .i_radian_accuracy (i_radian_accuracy),
        .i_target_vector   (i_target_vector),
        .i_angle_value     (i_angle_value),
        .o_vector_kind     (o_vector_kind),
        .o_yaw_deg         (o_yaw_deg),
        .o_pitch_deg       (o_pitch_deg),
        .o_roll_deg        (o_roll_deg),
        .o_accuracy_deg    (o_accuracy_deg),
        .o_accuracy_status (o_accuracy_status),
        .o_rot_real        (o_rot_real),
        .o_rot_i           (o_rot_i),
        .o_rot_j           (o_rot_j),
        .o_rot_k           (o_rot_k)
    );
endmodule

/* dv/imu_quaternion_report_to_euler_tb.sv */
// testbench for the orientation report to euler angle converter
`timescale 1ns / 100ps

module imu_quaternion_report_to_euler_tb;
    import iqe_pkg::*;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic [1:0] TGT_NONE = 2'd3;

    typedef struct {
        logic              req_type;
        logic [15:0]       header_length;
        logic [7:0]        report_id;
        logic [1:0]        status_bits;
        logic signed [15:0] quat_i, quat_j, quat_k, quat_real, radian_accuracy;
        logic [1:0]        target_vector;
        logic signed [25:0] angle_value;
    } t_report;

    typedef struct packed {
        logic               vector_kind;
        logic [24:0]        yaw_deg;
        logic signed [24:0] pitch_deg;
        logic signed [23:0] roll_deg;
        logic signed [23:0] accuracy_deg;
        logic [1:0]         accuracy_status;
        logic signed [15:0] rot_real, rot_i, rot_j, rot_k;
    } t_angles;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_in_valid = 1'b0, i_out_ready = 1'b0;
    logic o_in_ready, o_out_valid;
    t_report cur = '{default: '0};
    logic i_cfg_we = 1'b0, i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    t_angles got;

    t_report pending_reports[$];
    t_angles expected_angles[$];
    int errors = 0;
    bit quiet_phase = 1'b0;
    int in_gap = 0, out_gap = 0;

    // predictor state
    logic [7:0] rot_id, game_id;
    longint rot_offset, game_offset, last_rot_yaw, last_game_yaw;
    logic [7:0] rot_id_cfg = 8'd5, game_id_cfg = 8'd8;

    imu_quaternion_report_to_euler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(cur.req_type), .i_header_length(cur.header_length),
        .i_report_id(cur.report_id), .i_status_bits(cur.status_bits),
        .i_quat_i(cur.quat_i), .i_quat_j(cur.quat_j), .i_quat_k(cur.quat_k),
        .i_quat_real(cur.quat_real), .i_radian_accuracy(cur.radian_accuracy),
        .i_target_vector(cur.target_vector), .i_angle_value(cur.angle_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_vector_kind(got.vector_kind), .o_yaw_deg(got.yaw_deg),
        .o_pitch_deg(got.pitch_deg), .o_roll_deg(got.roll_deg),
        .o_accuracy_deg(got.accuracy_deg), .o_accuracy_status(got.accuracy_status),
        .o_rot_real(got.rot_real), .o_rot_i(got.rot_i), .o_rot_j(got.rot_j),
        .o_rot_k(got.rot_k),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint round_up_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint atan_table(int k);
        longint t[24] = '{754974720, 445687602, 235489089, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
            117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[k];
    endfunction

    // vectoring cordic, degrees * 2^24
    function automatic longint atan2_q24(longint y, longint x);
        longint half_turn, z, xs, ys;
        half_turn = longint'(180) << ACC_FRAC;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? half_turn : -half_turn;
            x = -x;
            y = -y;
        end
        for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
            xs = floor_shift(x, k);
            ys = floor_shift(y, k);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z += atan_table(k);
            end else begin
                x = x - ys; y = y + xs; z -= atan_table(k);
            end
        end
        return clip(z, -half_turn, half_turn);
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // updates predictor state and returns 1 when a result is due
    function automatic bit predict_angles(t_report it, output t_angles a);
        longint full, s[4], q16[4], q14[4], r, i, j, k, v, raw, yaw, acc;
        longint unsigned cosv;
        longint unsigned len;
        bit kind;
        full = longint'(360) << ANGLE_FRAC_BITS;
        a = '{default: '0};
        if (it.req_type == REQ_SET) begin
            case (it.target_vector)
                TGT_ROT:  rot_offset = longint'(it.angle_value);
                TGT_GAME: game_offset = longint'(it.angle_value);
                TGT_AZ: begin
                    rot_offset = longint'(int'(it.angle_value - last_rot_yaw));
                    game_offset = longint'(int'(it.angle_value - last_game_yaw));
                end
                default: ;
            endcase
            return 1'b0;
        end
        len = 64'(it.header_length[14:0]);
        if (it.report_id == rot_id) kind = 1'b0;
        else if (it.report_id == game_id) kind = 1'b1;
        else return 1'b0;
        r = (len > 18) ? longint'(it.quat_real) : 0;
        acc = (len > 20) ? longint'(it.radian_accuracy) : 0;
        s[0] = r - it.quat_j;
        s[1] = longint'(it.quat_i) - it.quat_k;
        s[2] = r + it.quat_j;
        s[3] = longint'(it.quat_i) + it.quat_k;
        for (int n = 0; n < 4; n++) begin
            q16[n] = round_up_shift(s[n] * 46341, 14);
            q14[n] = clip(round_up_shift(s[n] * 46341, 16), -32768, 32767);
        end
        r = q16[0]; i = q16[1]; j = q16[2]; k = q16[3];
        raw = -round_up_shift(atan2_q24(i*j + r*k, r*r + i*i - (longint'(1) << 31)), 8);
        if (raw < 0) raw += full;
        a.pitch_deg = 25'(round_up_shift(
            atan2_q24(r*i + j*k, r*r + k*k - (longint'(1) << 31)), 8));
        v = clip(floor_shift(i*k - r*j, 1), -(longint'(1) << 30), longint'(1) << 30);
        cosv = (64'd1 << 60) - longint'(v * v);
        a.roll_deg = 24'(-round_up_shift(atan2_q24(v, floor_sqrt(cosv)), 8));
        if (!kind) begin
            last_rot_yaw = raw; yaw = raw + rot_offset;
        end else begin
            last_game_yaw = raw; yaw = raw + game_offset;
        end
        if (yaw > full) yaw -= full;
        if (yaw < 0) yaw += full;
        a.yaw_deg = 25'(clip(yaw, 0, full));
        a.accuracy_deg = 24'(round_up_shift(acc * 3754936, 30 - ANGLE_FRAC_BITS));
        a.vector_kind = kind;
        a.accuracy_status = it.status_bits;
        a.rot_real = 16'(q14[0]); a.rot_i = 16'(q14[1]);
        a.rot_j = 16'(q14[2]); a.rot_k = 16'(q14[3]);
        return 1'b1;
    endfunction

    // driver
    logic took_in = 1'b0;
    always @(posedge i_clk) begin
        took_in <= i_rst_n && i_in_valid && o_in_ready;
    end

    always @(negedge i_clk) begin
        t_angles a;
        if (i_rst_n) begin
            if (took_in) begin
                if (predict_angles(cur, a)) expected_angles.push_back(a);
            end
            if (!i_in_valid || took_in) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reports.size() > 0) begin
                    cur <= pending_reports.pop_front();
                    i_in_valid <= 1'b1;
                    if (!quiet_phase && $urandom_range(0, 7) == 0)
                        in_gap = $urandom_range(1, 16);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 9) == 0)
                    out_gap = $urandom_range(1, 16);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_angles e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_angles.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item");
            end else begin
                e = expected_angles.pop_front();
                if (got !== e) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %p got %p", e, got);
                end
            end
        end
    end

    function automatic t_report random_report(bit known);
        t_report it;
        it.req_type = REQ_REPORT;
        it.header_length = 16'($urandom);
        if ($urandom_range(0, 3) != 0) it.header_length[14:0] = 15'($urandom_range(17, 24));
        it.report_id = known ? ($urandom_range(0, 1) ? rot_id_cfg : game_id_cfg)
                             : 8'($urandom);
        it.status_bits = 2'($urandom);
        it.quat_i = 16'($urandom); it.quat_j = 16'($urandom);
        it.quat_k = 16'($urandom); it.quat_real = 16'($urandom);
        it.radian_accuracy = 16'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            // small unit-ish quaternions
            it.quat_i = 16'(int'($urandom_range(0, 32768)) - 16384);
            it.quat_j = 16'(int'($urandom_range(0, 32768)) - 16384);
            it.quat_k = 16'(int'($urandom_range(0, 32768)) - 16384);
            it.quat_real = 16'(int'($urandom_range(0, 32768)) - 16384);
        end
        it.target_vector = 2'($urandom);
        it.angle_value = 26'($urandom);
        return it;
    endfunction

    function automatic t_report set_request(logic [1:0] tgt, int val);
        t_report it;
        it = '{default: '0};
        it.req_type = REQ_SET;
        it.target_vector = tgt;
        it.angle_value = 26'(val);
        it.header_length = 16'($urandom);
        it.quat_i = 16'($urandom);
        return it;
    endfunction

    task automatic write_id(logic idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_ROT_ID) rot_id = val; else game_id = val;
        if (idx == CFG_ROT_ID) rot_id_cfg = val; else game_id_cfg = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (pending_reports.size() > 0 || i_in_valid || took_in ||
               expected_angles.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        t_report it;
        int full;
        full = 360 << 16;
        rot_id = 8'd5; game_id = 8'd8;
        rot_offset = 0; game_offset = 0; last_rot_yaw = 0; last_game_yaw = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, short packets, both kinds, every set target
        it = random_report(1'b1);
        it.report_id = 8'd5; it.header_length = 16'hFFFF;
        it.quat_i = 16'sh7FFF; it.quat_j = 16'sh7FFF; it.quat_k = 16'sh7FFF;
        it.quat_real = 16'sh7FFF; it.radian_accuracy = 16'sh7FFF;
        pending_reports.push_back(it);
        it.report_id = 8'd8; it.quat_i = -16'sd32768; it.quat_j = -16'sd32768;
        it.quat_k = -16'sd32768; it.quat_real = -16'sd32768;
        it.radian_accuracy = -16'sd32768;
        pending_reports.push_back(it);
        it = '{default: '0}; it.report_id = 8'd5; it.header_length = 16'd24;
        pending_reports.push_back(it);      // zero-length vector
        it.header_length = 16'd18; it.quat_real = 16'sd16384; it.quat_i = 16'sd100;
        pending_reports.push_back(it);      // real dropped
        it.header_length = 16'd20; it.radian_accuracy = 16'sd500;
        pending_reports.push_back(it);      // accuracy dropped
        it.header_length = 16'h8015;
        pending_reports.push_back(it);      // bit 15 ignored
        it.quat_real = 16'sd16384; it.quat_i = 16'sd0; it.quat_j = 16'sd0;
        it.quat_k = 16'sd0; it.header_length = 16'd24;
        pending_reports.push_back(it);      // identity, pitch/roll edge
        it.quat_real = 16'sd11585; it.quat_j = 16'sd11585;
        pending_reports.push_back(it);      // equal real and j parts, asin argument zero
        it.report_id = 8'd77;
        pending_reports.push_back(it);      // unknown id
        pending_reports.push_back(set_request(TGT_ROT, full));
        pending_reports.push_back(set_request(TGT_GAME, -full));
        for (int n = 0; n < 4; n++) pending_reports.push_back(random_report(1'b1));
        pending_reports.push_back(set_request(TGT_AZ, 12345678));
        pending_reports.push_back(set_request(TGT_NONE, 999));
        pending_reports.push_back(set_request(TGT_ROT, 26'sh1FFFFFF));
        pending_reports.push_back(set_request(TGT_GAME, -33554432));
        for (int n = 0; n < 4; n++) pending_reports.push_back(random_report(1'b1));
        pending_reports.push_back(set_request(TGT_AZ, -full));
        drain();

        // random phases with different report ids, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_id(CFG_ROT_ID, 8'd0); write_id(CFG_GAME_ID, 8'd255); end
                1: begin write_id(CFG_ROT_ID, 8'd255); write_id(CFG_GAME_ID, 8'd0); end
                2: begin write_id(CFG_ROT_ID, 8'd42); write_id(CFG_GAME_ID, 8'd42); end
                default: begin write_id(CFG_ROT_ID, 8'd5); write_id(CFG_GAME_ID, 8'd8); end
            endcase
            if (ph == 3) quiet_phase = 1'b1;
            for (int n = 0; n < 150; n++) begin
                case ($urandom_range(0, 9))
                    0: pending_reports.push_back(random_report(1'b0));
                    1: pending_reports.push_back(set_request(2'($urandom),
                           int'($urandom_range(0, 2 * 23592960)) - 23592960));
                    default: pending_reports.push_back(random_report(1'b1));
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
